### rtl/pgfb_pkg.sv
// ----------------------------------------------------------------------------
// pgfb_pkg - shared constants and types for the process grid balance core
// Default sizes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pgfb_pkg;

    localparam int MAX_AXES_DEF    = 8;
    localparam int MAX_FACTORS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 16;
    localparam int PROC_BITS       = 16;
    localparam int STATUS_BITS     = 2;

    localparam logic [STATUS_BITS-1:0] ST_BALANCED  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_UNCHANGED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_SPLIT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_LOAD_WAIT,
        S_FCHK,
        S_EVEN,
        S_TRIAL,
        S_TRIAL_WAIT,
        S_FINAL,
        S_AP_NEXT,
        S_SCAN,
        S_AP_SEL,
        S_AP_WAIT,
        S_EMIT
    } state_t;

endpackage

### rtl/process_grid_factor_balance_core.sv
// ----------------------------------------------------------------------------
// process_grid_factor_balance_core - spreads a process count over grid axes
// Collects axes, factors the leftover count and hands factors to long axes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken when start is high and busy is low, one axis per
//   beat (axis_request, axis_length, last_axis). A non-last beat is stored
//   while room is left. The beat with last_axis set starts the computation;
//   busy stays high until all n results are out. proc_count is written through
//   cfg_we / cfg_wdata while the core is idle.
//   Results come out one per cycle on axis_parts/status/last_result, each
//   marked by a one-cycle result_valid pulse; the receiver cannot stall them.
// Sequence: one shared restoring divider serves every division.
//   The leftover pass divides proc_count by each axis's starting count;
//   factoring strips factors of two, then trial-divides by odd divisors;
//   placement divides an axis's remaining length by each factor; then the
//   n results are emitted. Trial division of a large leftover dominates.
// Reset: proc_count returns to 1 and any partly loaded set is dropped.
// ----------------------------------------------------------------------------
module process_grid_factor_balance_core
    import pgfb_pkg::*;
#(
    parameter int MAX_AXES    = MAX_AXES_DEF,
    parameter int MAX_FACTORS = MAX_FACTORS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS:0]   axis_request,
    input  logic        [VALUE_BITS-1:0] axis_length,
    input  logic                         last_axis,
    input  logic                         cfg_we,
    input  logic        [PROC_BITS-1:0]  cfg_wdata,
    output logic                         result_valid,
    output logic signed [VALUE_BITS:0]   axis_parts,
    output logic        [STATUS_BITS-1:0] status,
    output logic                         last_result
);

    localparam int VB    = VALUE_BITS;
    localparam int CNT_W = $clog2(MAX_AXES + 1);
    localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int FC_W  = $clog2(MAX_FACTORS + 1);
    localparam int FI_W  = $clog2(MAX_FACTORS);
    localparam int DC_W  = $clog2(VB + 1);
    localparam int SQ_W  = VB + 2;

    state_t state_reg, state_next;

    logic [PROC_BITS-1:0] proc_count_reg;

    logic [VB:0]   req_store_reg   [MAX_AXES];
    logic [VB-1:0] len_store_reg   [MAX_AXES];
    logic [VB-1:0] parts_store_reg [MAX_AXES];
    logic [VB-1:0] rem_len_reg     [MAX_AXES];
    logic [VB-1:0] fac_store_reg   [MAX_FACTORS];

    logic [CNT_W-1:0] axis_count_reg, axis_count_next;
    logic             zero_seen_reg, zero_seen_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic             found_reg, found_next;
    logic [VB-1:0]    best_len_reg, best_len_next;
    logic [VB-1:0]    leftover_reg, leftover_next;
    logic [FC_W-1:0]  fac_count_reg, fac_count_next;
    logic [FC_W-1:0]  fac_idx_reg, fac_idx_next;
    logic [VB-1:0]    trial_reg, trial_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [STATUS_BITS-1:0] st_reg, st_next;

    // shared divider
    logic [VB-1:0]   div_quo_reg, div_quo_next;
    logic [VB-1:0]   div_rem_reg, div_rem_next;
    logic [VB-1:0]   div_den_reg, div_den_next;
    logic [DC_W-1:0] div_cnt_reg, div_cnt_next;

    logic                   result_valid_reg, result_valid_next;
    logic [VB:0]            axis_parts_reg, axis_parts_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   last_result_reg, last_result_next;

    // array write ports
    logic             in_we;
    logic             parts_we, rem_we, fac_we;
    logic [VB-1:0]    parts_wdata, rem_wdata, fac_wdata;

    // common terms
    logic             accept, item_store, zero_hit, idx_last, div_done, fac_room;
    logic [VB:0]      req_rd;
    logic [VB-1:0]    len_rd, parts_rd, rem_rd, fac_rd, load_p;
    logic [VB:0]      div_sh, div_diff;
    logic [2*VB-1:0]  prod;

    assign accept     = start && (state_reg == S_IDLE);
    assign item_store = axis_count_reg < CNT_W'(MAX_AXES);
    assign zero_hit   = zero_seen_reg || (item_store && (axis_request == '0));
    assign idx_last   = (CNT_W'(idx_reg) + CNT_W'(1)) == n_reg;
    assign div_done   = (div_cnt_reg == '0);
    assign fac_room   = fac_count_reg < FC_W'(MAX_FACTORS);

    assign req_rd   = req_store_reg[idx_reg];
    assign len_rd   = len_store_reg[idx_reg];
    assign parts_rd = parts_store_reg[idx_reg];
    assign rem_rd   = rem_len_reg[idx_reg];
    assign fac_rd   = fac_store_reg[fac_idx_reg[FI_W-1:0]];
    // negative request counts as one process to start with
    assign load_p   = req_rd[VB] ? VB'(1) : req_rd[VB-1:0];

    assign div_sh   = {div_rem_reg, div_quo_reg[VB-1]};
    assign div_diff = div_sh - {1'b0, div_den_reg};
    assign prod     = (2*VB)'(parts_rd) * (2*VB)'(div_den_reg);

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign axis_parts   = axis_parts_reg;
    assign status       = status_reg;
    assign last_result  = last_result_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && last_axis)
                    state_next = zero_hit ? S_EMIT : S_LOAD;
            end
            S_LOAD:
                state_next = S_LOAD_WAIT;
            S_LOAD_WAIT:
            begin
                if (div_done)
                    state_next = idx_last ? S_FCHK : S_LOAD;
            end
            S_FCHK:
            begin
                if (leftover_reg == '0)
                    state_next = S_EMIT;
                else if (leftover_reg == VB'(1))
                    state_next = S_AP_NEXT;
                else
                    state_next = S_EVEN;
            end
            S_EVEN:
            begin
                if (leftover_reg[0])
                    state_next = S_TRIAL;
            end
            S_TRIAL:
                state_next = (sq_reg > SQ_W'(leftover_reg)) ? S_FINAL : S_TRIAL_WAIT;
            S_TRIAL_WAIT:
            begin
                if (div_done)
                    state_next = S_TRIAL;
            end
            S_FINAL:
                state_next = S_AP_NEXT;
            S_AP_NEXT:
                state_next = (fac_idx_reg == '0) ? S_EMIT : S_SCAN;
            S_SCAN:
            begin
                if (idx_last)
                    state_next = S_AP_SEL;
            end
            S_AP_SEL:
                state_next = found_reg ? S_AP_WAIT : S_AP_NEXT;
            S_AP_WAIT:
            begin
                if (div_done)
                    state_next = (div_quo_reg == '0) ? S_EMIT : S_AP_NEXT;
            end
            S_EMIT:
            begin
                if (idx_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        axis_count_next   = axis_count_reg;
        zero_seen_next    = zero_seen_reg;
        n_next            = n_reg;
        idx_next          = idx_reg;
        best_next         = best_reg;
        found_next        = found_reg;
        best_len_next     = best_len_reg;
        leftover_next     = leftover_reg;
        fac_count_next    = fac_count_reg;
        fac_idx_next      = fac_idx_reg;
        trial_next        = trial_reg;
        sq_next           = sq_reg;
        st_next           = st_reg;
        result_valid_next = 1'b0;
        axis_parts_next   = axis_parts_reg;
        status_next       = status_reg;
        last_result_next  = last_result_reg;
        in_we             = 1'b0;
        parts_we          = 1'b0;
        parts_wdata       = load_p;
        rem_we            = 1'b0;
        rem_wdata         = len_rd;
        fac_we            = 1'b0;
        fac_wdata         = VB'(2);

        // one restoring step per cycle while a division runs
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        if (!div_done)
        begin
            div_cnt_next = div_cnt_reg - DC_W'(1);
            if (!div_diff[VB])
            begin
                div_rem_next = div_diff[VB-1:0];
                div_quo_next = {div_quo_reg[VB-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = div_sh[VB-1:0];
                div_quo_next = {div_quo_reg[VB-2:0], 1'b0};
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    in_we = item_store;
                    if (item_store)
                        axis_count_next = axis_count_reg + CNT_W'(1);
                    zero_seen_next = zero_hit;
                    if (last_axis)
                    begin
                        n_next          = item_store ? axis_count_reg + CNT_W'(1)
                                                     : axis_count_reg;
                        axis_count_next = '0;
                        zero_seen_next  = 1'b0;
                        idx_next        = '0;
                        fac_count_next  = '0;
                        leftover_next   = VB'(proc_count_reg);
                        st_next         = zero_hit ? ST_UNCHANGED : ST_BALANCED;
                    end
                end
            end
            S_LOAD:
            begin
                parts_we     = 1'b1;
                rem_we       = 1'b1;
                div_quo_next = leftover_reg;
                div_rem_next = '0;
                div_den_next = load_p;
                div_cnt_next = DC_W'(VB);
            end
            S_LOAD_WAIT:
            begin
                if (div_done)
                begin
                    leftover_next = div_quo_reg;
                    idx_next      = idx_last ? '0 : idx_reg + IDX_W'(1);
                end
            end
            S_FCHK:
            begin
                fac_count_next = '0;
                if (leftover_reg == '0)
                begin
                    st_next  = ST_NO_SPLIT;
                    idx_next = '0;
                end
                else if (leftover_reg == VB'(1))
                begin
                    // unit leftover still goes through as a single factor of one
                    fac_we         = 1'b1;
                    fac_wdata      = VB'(1);
                    fac_count_next = FC_W'(1);
                    fac_idx_next   = FC_W'(1);
                end
            end
            S_EVEN:
            begin
                if (!leftover_reg[0])
                begin
                    fac_we        = fac_room;
                    fac_wdata     = VB'(2);
                    if (fac_room)
                        fac_count_next = fac_count_reg + FC_W'(1);
                    leftover_next = leftover_reg >> 1;
                end
                else
                begin
                    trial_next = VB'(3);
                    sq_next    = SQ_W'(9);
                end
            end
            S_TRIAL:
            begin
                if (sq_reg <= SQ_W'(leftover_reg))
                begin
                    div_quo_next = leftover_reg;
                    div_rem_next = '0;
                    div_den_next = trial_reg;
                    div_cnt_next = DC_W'(VB);
                end
            end
            S_TRIAL_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem_reg == '0)
                    begin
                        fac_we        = fac_room;
                        fac_wdata     = trial_reg;
                        if (fac_room)
                            fac_count_next = fac_count_reg + FC_W'(1);
                        leftover_next = div_quo_reg;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        trial_next = trial_reg + VB'(2);
                        sq_next    = sq_reg + {trial_reg, 2'b00} + SQ_W'(4);
                    end
                end
            end
            S_FINAL:
            begin
                if (leftover_reg > VB'(2))
                begin
                    fac_we    = fac_room;
                    fac_wdata = leftover_reg;
                    if (fac_room)
                    begin
                        fac_count_next = fac_count_reg + FC_W'(1);
                        fac_idx_next   = fac_count_reg + FC_W'(1);
                    end
                    else
                        fac_idx_next = fac_count_reg;
                end
                else
                    fac_idx_next = fac_count_reg;
            end
            S_AP_NEXT:
            begin
                idx_next      = '0;
                found_next    = 1'b0;
                best_len_next = '0;
                if (fac_idx_reg != '0)
                    fac_idx_next = fac_idx_reg - FC_W'(1);
            end
            S_SCAN:
            begin
                // later axis wins a tie
                if (req_rd[VB] && (best_len_reg <= rem_rd))
                begin
                    best_next     = idx_reg;
                    best_len_next = rem_rd;
                    found_next    = 1'b1;
                end
                if (!idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_AP_SEL:
            begin
                if (found_reg)
                begin
                    idx_next     = best_reg;
                    div_quo_next = best_len_reg;
                    div_rem_next = '0;
                    div_den_next = fac_rd;
                    div_cnt_next = DC_W'(VB);
                end
            end
            S_AP_WAIT:
            begin
                if (div_done)
                begin
                    if (div_quo_reg == '0)
                    begin
                        st_next  = ST_NO_SPLIT;
                        idx_next = '0;
                    end
                    else
                    begin
                        rem_we      = 1'b1;
                        rem_wdata   = div_quo_reg;
                        parts_we    = 1'b1;
                        parts_wdata = prod[VB-1:0];
                    end
                end
            end
            S_EMIT:
            begin
                result_valid_next = 1'b1;
                axis_parts_next   = (st_reg == ST_BALANCED) ? {1'b0, parts_rd} : req_rd;
                status_next       = st_reg;
                last_result_next  = idx_last;
                if (!idx_last)
                    idx_next = idx_reg + IDX_W'(1);
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            proc_count_reg   <= PROC_BITS'(1);
            axis_count_reg   <= '0;
            zero_seen_reg    <= 1'b0;
            fac_count_reg    <= '0;
            fac_idx_reg      <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
                proc_count_reg <= cfg_wdata;
            axis_count_reg   <= axis_count_next;
            zero_seen_reg    <= zero_seen_next;
            fac_count_reg    <= fac_count_next;
            fac_idx_reg      <= fac_idx_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        idx_reg         <= idx_next;
        best_reg        <= best_next;
        found_reg       <= found_next;
        best_len_reg    <= best_len_next;
        leftover_reg    <= leftover_next;
        trial_reg       <= trial_next;
        sq_reg          <= sq_next;
        st_reg          <= st_next;
        div_quo_reg     <= div_quo_next;
        div_rem_reg     <= div_rem_next;
        div_den_reg     <= div_den_next;
        axis_parts_reg  <= axis_parts_next;
        status_reg      <= status_next;
        last_result_reg <= last_result_next;
    end

    // axis and factor stores
    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            req_store_reg[axis_count_reg[IDX_W-1:0]] <= axis_request;
            len_store_reg[axis_count_reg[IDX_W-1:0]] <= axis_length;
        end
        if (parts_we)
            parts_store_reg[idx_reg] <= parts_wdata;
        if (rem_we)
            rem_len_reg[idx_reg] <= rem_wdata;
        if (fac_we)
            fac_store_reg[fac_count_reg[FI_W-1:0]] <= fac_wdata;
    end

endmodule

### tb/sv/process_grid_factor_balance_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_grid_factor_balance_core_tb - self-checking bench for the grid balancer
// Feeds axis sets under several process counts and predicts each set's
// balanced counts. Every result beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module process_grid_factor_balance_core_tb;
    import pgfb_pkg::*;

    localparam int VB            = VALUE_BITS_DEF;
    localparam int NAX           = MAX_AXES_DEF;
    localparam int NFAC          = MAX_FACTORS_DEF;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int IDLE_LIMIT    = 40000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 260;

    typedef struct packed {
        logic signed [VB:0]   req;
        logic        [VB-1:0] len;
        logic                 last;
    } axis_beat_t;

    typedef struct packed {
        logic [VB:0]            parts;
        logic [STATUS_BITS-1:0] st;
        logic                   last;
    } axis_result_t;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic signed [VB:0]      axis_request = '0;
    logic        [VB-1:0]    axis_length  = '0;
    logic                    last_axis    = 1'b0;
    logic                    cfg_we       = 1'b0;
    logic [PROC_BITS-1:0]    cfg_wdata    = '0;
    logic                    result_valid;
    logic signed [VB:0]      axis_parts;
    logic [STATUS_BITS-1:0]  status;
    logic                    last_result;

    // pending input beats, popped by the driver once accepted
    axis_beat_t   axis_beats[$];
    axis_result_t parts_expected[$];

    // predictor state
    logic [PROC_BITS-1:0] proc_cfg = 16'd1;
    logic [VB:0]          held_req[NAX];
    logic [VB-1:0]        held_len[NAX];
    logic [VB-1:0]        held_parts[NAX];
    int                   held_count = 0;
    bit                   held_zero  = 1'b0;
    longint unsigned      factor_list[NFAC];
    int                   factor_total = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;
    bit beat_taken     = 1'b0;
    int gap_left       = 0;
    int burst_left     = 0;

    process_grid_factor_balance_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .axis_request (axis_request),
        .axis_length  (axis_length),
        .last_axis    (last_axis),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .axis_parts   (axis_parts),
        .status       (status),
        .last_result  (last_result)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic void add_factor(input longint unsigned f);
        if (factor_total < NFAC)
        begin
            factor_list[factor_total] = f;
            factor_total++;
        end
    endfunction

    function automatic logic [STATUS_BITS-1:0] balance_held_axes(input int n);
        longint unsigned rem[NAX];
        longint unsigned left;
        longint unsigned m;
        longint unsigned d;
        longint unsigned f;
        longint unsigned best_len;
        int best;
        int i;
        int k;
        if (held_zero)
            return ST_UNCHANGED;
        left = proc_cfg;
        for (i = 0; i < n; i++)
        begin
            held_parts[i] = held_req[i][VB] ? 16'd1 : held_req[i][VB-1:0];
            rem[i] = held_len[i];
            left = left / held_parts[i];
        end
        if (left < 1)
            return ST_NO_SPLIT;
        // trial division, factors in nondecreasing order
        factor_total = 0;
        m = left;
        if (m <= 1)
            add_factor(1);
        else
        begin
            while (m % 2 == 0)
            begin
                add_factor(2);
                m = m / 2;
            end
            for (d = 3; d * d <= m; d += 2)
            begin
                while (m % d == 0)
                begin
                    add_factor(d);
                    m = m / d;
                end
            end
            if (m > 2)
                add_factor(m);
        end
        // largest factor first, onto the longest fill-in axis (later axis wins ties)
        for (k = factor_total - 1; k >= 0; k--)
        begin
            f = factor_list[k];
            best = -1;
            best_len = 0;
            for (i = 0; i < n; i++)
            begin
                if (held_req[i][VB] && best_len <= rem[i])
                begin
                    best = i;
                    best_len = rem[i];
                end
            end
            if (best >= 0)
            begin
                rem[best] = rem[best] / f;
                if (rem[best] < 1)
                    return ST_NO_SPLIT;
                held_parts[best] = VB'(held_parts[best] * f);
            end
        end
        return ST_BALANCED;
    endfunction

    task automatic take_axis(input logic [VB:0] req, input logic [VB-1:0] len,
                             input logic last);
        logic [STATUS_BITS-1:0] st;
        axis_result_t r;
        int i;
        // beyond the axis limit the beat only counts for its last mark
        if (held_count < NAX)
        begin
            held_req[held_count] = req;
            held_len[held_count] = len;
            if (req == 0)
                held_zero = 1'b1;
            held_count++;
        end
        if (last)
        begin
            st = balance_held_axes(held_count);
            for (i = 0; i < held_count; i++)
            begin
                r.parts = (st == ST_BALANCED) ? {1'b0, held_parts[i]} : held_req[i];
                r.st    = st;
                r.last  = (i == held_count - 1);
                parts_expected.push_back(r);
            end
            held_count = 0;
            held_zero  = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return -1;
        if (r < 70)
            return -$urandom_range(2, 65536);
        if (r < 88)
            return $urandom_range(1, 8);
        if (r < 96)
            return $urandom_range(9, 65535);
        return 0;
    endfunction

    function automatic int rand_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 65535);
        if (r < 85)
            return $urandom_range(1, 64);
        if (r < 95)
            return 65535;
        return $urandom_range(1, 4);
    endfunction

    function automatic int pick_proc_count();
        int v;
        int f;
        case ($urandom_range(0, 6))
            0: return 65535;
            1: return 1;
            2: return 1 << $urandom_range(0, 15);
            5:
            begin
                // smooth numbers give long factor lists
                v = 1;
                repeat ($urandom_range(1, 14))
                begin
                    case ($urandom_range(0, 3))
                        0: f = 2;
                        1: f = 3;
                        2: f = 5;
                        default: f = 7;
                    endcase
                    if (v * f <= 65535)
                        v = v * f;
                end
                return v;
            end
            6: return $urandom_range(60000, 65535);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    task automatic push_axis(input int req, input int len, input bit last);
        axis_beat_t b;
        b.req  = (VB+1)'(req);
        b.len  = VB'(len);
        b.last = last;
        axis_beats.push_back(b);
    endtask

    task automatic write_proc_count(input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= PROC_BITS'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        proc_cfg   = PROC_BITS'(value);
        @(posedge clk);
    endtask

    // hold the sender until every result is back and the core has gone quiet
    task automatic wait_for_idle();
        while (axis_beats.size() != 0 || parts_expected.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : drive_beats
        axis_beat_t nxt;
        bit nxt_start;
        nxt_start = 1'b0;
        if (rst_n)
        begin
            if (beat_taken)
            begin
                void'(axis_beats.pop_front());
                gap_left = pick_gap();
            end
            if (gap_left > 0)
                gap_left--;
            else if (axis_beats.size() > 0)
            begin
                nxt = axis_beats[0];
                axis_request <= nxt.req;
                axis_length  <= nxt.len;
                last_axis    <= nxt.last;
                nxt_start     = 1'b1;
            end
        end
        start <= nxt_start;
    end

    always @(posedge clk)
    begin : watch_results
        axis_result_t want;
        bit took;
        took = rst_n && start && !busy;
        beat_taken <= took;
        if (rst_n && result_valid)
        begin
            if (parts_expected.size() == 0)
                report_mismatch("unexpected result beat", axis_parts, 0);
            else
            begin
                want = parts_expected.pop_front();
                if (axis_parts !== want.parts)
                    report_mismatch("axis_parts", axis_parts, want.parts);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (last_result !== want.last)
                    report_mismatch("last_result", last_result, want.last);
            end
        end
        if (took)
            take_axis(axis_request, axis_length, last_axis);
        if (took || (rst_n && result_valid))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : run_test
        int made;
        int phase_items;
        int phase_size;
        int n;
        int i;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // process count still at its reset value of one
        push_axis(-1, 65535, 0);
        push_axis(-1, 1, 1);
        push_axis(5, 100, 1);
        wait_for_idle();

        write_proc_count(65535);
        push_axis(-1, 65535, 0);
        push_axis(-1, 65535, 0);
        push_axis(-1, 1, 1);
        // zero request leaves the set alone
        push_axis(0, 10, 0);
        push_axis(-1, 20, 1);
        // fixed axes only
        push_axis(3, 1, 0);
        push_axis(7, 2, 1);
        // remaining length runs out
        push_axis(-1, 2, 1);
        push_axis(65535, 1, 0);
        push_axis(-1, 8, 1);
        // more axes than the core holds; the dropped zero must not count
        push_axis(-1, 40000, 0);
        push_axis(-65536, 300, 0);
        push_axis(-2, 65535, 0);
        push_axis(3, 7, 0);
        push_axis(-1, 65535, 0);
        push_axis(-3, 2, 0);
        push_axis(-1, 1, 0);
        push_axis(-100, 9000, 0);
        push_axis(0, 5, 0);
        push_axis(-1, 5, 1);
        wait_for_idle();

        write_proc_count(0);
        push_axis(-1, 100, 0);
        push_axis(4, 100, 1);
        wait_for_idle();

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            write_proc_count(pick_proc_count());
            phase_items = 0;
            phase_size = $urandom_range(20, 50);
            while (phase_items < phase_size)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(NAX + 1, NAX + 3)
                                                : $urandom_range(1, NAX);
                for (i = 0; i < n; i++)
                    push_axis(rand_request(), rand_length(), i == n - 1);
                phase_items += n;
                if ($urandom_range(0, 7) == 0)
                    wait_for_idle();
            end
            made += phase_items;
            wait_for_idle();
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/pgfb_pkg.sv
rtl/process_grid_factor_balance_core.sv
tb/sv/process_grid_factor_balance_core_tb.sv
